FILE: hw/rtl/des_pkg.sv
// ----------------------------------------------------------------------------
// des_pkg
// Shared types and constants of the daily event scheduler: field widths,
// command codes, controller states and the entry, control and status structs.
// ----------------------------------------------------------------------------
package des_pkg;

	localparam int CMD_W   = 2;
	localparam int SLOT_W  = 4;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int COUNT_W = 5;

	typedef enum logic [1:0] {
		CMD_WRITE   = 2'd0,
		CMD_FIND    = 2'd1,
		CMD_RESTORE = 2'd2,
		CMD_EXECUTE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_MID_CHK,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_APPLY,
		ST_OUT_RD,
		ST_OUT_LOAD
	} state_t;

	typedef enum logic [1:0] {
		RD_PEND,
		RD_PREV,
		RD_SCAN,
		RD_FIRST
	} rd_sel_t;

	typedef enum logic [2:0] {
		PEND_HOLD,
		PEND_NONE,
		PEND_ZERO,
		PEND_SCAN,
		PEND_ADVANCE
	} pend_op_t;

	typedef struct packed {
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
		logic              relay;
	} entry_t;

	typedef struct packed {
		logic     req_ready;
		logic     latch;
		logic     wr_en;
		rd_sel_t  rd_sel;
		pend_op_t pend_op;
		logic     scan_clear;
		logic     scan_inc;
		logic     apply;
		logic     load_out;
	} ctrl_t;

	typedef struct packed {
		logic req_valid;
		cmd_t cmd;
		logic count_zero;
		logic pend_none;
		logic pend_zero;
		logic mid_hit;
		logic later;
		logic scan_last;
		logic out_busy;
	} stat_t;

endpackage

FILE: hw/rtl/des_req_if.sv
// ----------------------------------------------------------------------------
// des_req_if
// Request channel: one command item with its entry and time fields.
// ----------------------------------------------------------------------------
interface des_req_if;
	logic                         valid;
	logic                         ready;
	logic [des_pkg::CMD_W-1:0]    command;
	logic [des_pkg::SLOT_W-1:0]   entry_index;
	logic [des_pkg::HOUR_W-1:0]   time_hours;
	logic [des_pkg::MIN_W-1:0]    time_minutes;
	logic                         relay_state;

	modport source (output valid, command, entry_index, time_hours, time_minutes,
		relay_state, input ready);
	modport sink (input valid, command, entry_index, time_hours, time_minutes,
		relay_state, output ready);
endinterface

FILE: hw/rtl/des_rsp_if.sv
// ----------------------------------------------------------------------------
// des_rsp_if
// Result channel: relay level and pending event after each item.
// ----------------------------------------------------------------------------
interface des_rsp_if #(
	parameter int PEND_W = 5
);
	logic                         valid;
	logic                         ready;
	logic                         relay_on;
	logic                         event_applied;
	logic                         pending_valid;
	logic [PEND_W-1:0]            pending_index;
	logic [des_pkg::HOUR_W-1:0]   pending_hours;
	logic [des_pkg::MIN_W-1:0]    pending_minutes;

	modport source (output valid, relay_on, event_applied, pending_valid, pending_index,
		pending_hours, pending_minutes, input ready);
	modport sink (input valid, relay_on, event_applied, pending_valid, pending_index,
		pending_hours, pending_minutes, output ready);
endinterface

FILE: hw/rtl/des_cfg_if.sv
// ----------------------------------------------------------------------------
// des_cfg_if
// Configuration write channel carrying the event count.
// ----------------------------------------------------------------------------
interface des_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [des_pkg::COUNT_W-1:0]   event_count;

	modport source (output valid, event_count, input ready);
	modport sink (input valid, event_count, output ready);
endinterface

FILE: hw/rtl/daily_event_scheduler.sv
// ----------------------------------------------------------------------------
// daily_event_scheduler
// Table of daily relay events with a pending-event pointer. One item at a
// time: write, restore and execute go through dispatch, an apply step when
// an event applies, and the output read and load; find walks the table
// through its single read port, a read and a check state per entry (at most
// the event count of entries), and skips the walk when the count is zero. A
// result still waiting in a stalled output register holds the load for as
// long as it waits. A result waiting in the output register does not block
// acceptance of the next item. The user must write the event count on the
// cfg channel only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module daily_event_scheduler #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	des_req_if.sink     req,
	des_rsp_if.source   rsp,
	des_cfg_if.sink     cfg
);

	des_pkg::ctrl_t ctrl;
	des_pkg::stat_t stat;

	des_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	des_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg),
		.ctrl   (ctrl),
		.stat   (stat)
	);

endmodule

FILE: hw/rtl/des_ctrl.sv
// ----------------------------------------------------------------------------
// des_ctrl
// Controller: sequences table access, the pending search and result load.
// ----------------------------------------------------------------------------
module des_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  des_pkg::stat_t  stat,
	output des_pkg::ctrl_t  ctrl
);

	des_pkg::state_t state_q;
	des_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= des_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		ctrl            = '0;
		ctrl.rd_sel     = des_pkg::RD_PEND;
		ctrl.pend_op    = des_pkg::PEND_HOLD;
		case (state_q)
			des_pkg::ST_IDLE: begin
				ctrl.req_ready = 1'b1;
				if (stat.req_valid) begin
					ctrl.latch = 1'b1;
					state_d    = des_pkg::ST_DISPATCH;
				end
			end
			des_pkg::ST_DISPATCH: begin
				case (stat.cmd)
					des_pkg::CMD_WRITE: begin
						ctrl.wr_en = 1'b1;
						state_d    = des_pkg::ST_OUT_RD;
					end
					des_pkg::CMD_FIND: begin
						if (stat.count_zero) begin
							ctrl.pend_op = des_pkg::PEND_NONE;
							state_d      = des_pkg::ST_OUT_RD;
						end else begin
							ctrl.rd_sel = des_pkg::RD_FIRST;
							state_d     = des_pkg::ST_MID_CHK;
						end
					end
					des_pkg::CMD_RESTORE: begin
						if (!stat.count_zero && !stat.pend_zero) begin
							ctrl.rd_sel = des_pkg::RD_PREV;
							state_d     = des_pkg::ST_APPLY;
						end else begin
							state_d = des_pkg::ST_OUT_RD;
						end
					end
					default: begin
						if (!stat.pend_none) begin
							ctrl.rd_sel = des_pkg::RD_PEND;
							state_d     = des_pkg::ST_APPLY;
						end else begin
							state_d = des_pkg::ST_OUT_RD;
						end
					end
				endcase
			end
			des_pkg::ST_MID_CHK: begin
				if (stat.mid_hit) begin
					ctrl.pend_op = des_pkg::PEND_ZERO;
					state_d      = des_pkg::ST_OUT_RD;
				end else begin
					ctrl.scan_clear = 1'b1;
					state_d         = des_pkg::ST_SCAN_RD;
				end
			end
			des_pkg::ST_SCAN_RD: begin
				ctrl.rd_sel = des_pkg::RD_SCAN;
				state_d     = des_pkg::ST_SCAN_CHK;
			end
			des_pkg::ST_SCAN_CHK: begin
				if (stat.later) begin
					ctrl.pend_op = des_pkg::PEND_SCAN;
					state_d      = des_pkg::ST_OUT_RD;
				end else if (stat.scan_last) begin
					ctrl.pend_op = des_pkg::PEND_NONE;
					state_d      = des_pkg::ST_OUT_RD;
				end else begin
					ctrl.scan_inc = 1'b1;
					state_d       = des_pkg::ST_SCAN_RD;
				end
			end
			des_pkg::ST_APPLY: begin
				ctrl.apply = 1'b1;
				if (stat.cmd == des_pkg::CMD_EXECUTE) begin
					ctrl.pend_op = des_pkg::PEND_ADVANCE;
				end
				state_d = des_pkg::ST_OUT_RD;
			end
			des_pkg::ST_OUT_RD: begin
				ctrl.rd_sel = des_pkg::RD_PEND;
				state_d     = des_pkg::ST_OUT_LOAD;
			end
			des_pkg::ST_OUT_LOAD: begin
				if (!stat.out_busy) begin
					ctrl.load_out = 1'b1;
					state_d       = des_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = des_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hw/rtl/des_dp.sv
// ----------------------------------------------------------------------------
// des_dp
// Datapath: event table memory, pending slot, relay level, event count,
// scan index and the result register.
// ----------------------------------------------------------------------------
module des_dp #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	des_req_if.sink         req,
	des_rsp_if.source       rsp,
	des_cfg_if.sink         cfg,
	input  des_pkg::ctrl_t  ctrl,
	output des_pkg::stat_t  stat
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int PW = $clog2(TABLE_DEPTH + 1);

	des_pkg::entry_t mem [TABLE_DEPTH];
	des_pkg::entry_t rdata_q;
	logic [AW-1:0]   rd_addr;

	des_pkg::cmd_t                 cmd_q;
	logic [des_pkg::SLOT_W-1:0]    idx_q;
	logic [des_pkg::HOUR_W-1:0]    hh_q;
	logic [des_pkg::MIN_W-1:0]     mm_q;
	logic                          rs_q;

	logic [PW-1:0]                 pend_q;
	logic [AW-1:0]                 scan_q;
	logic [des_pkg::COUNT_W-1:0]   count_q;
	logic                          relay_q;
	logic                          applied_q;
	logic                          rsp_valid_q;
	logic                          pend_none;
	logic [31:0]                   pend_next;

	assign req.ready = ctrl.req_ready;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk) begin
		if (ctrl.latch) begin
			cmd_q <= des_pkg::cmd_t'(req.command);
			idx_q <= req.entry_index;
			hh_q  <= req.time_hours;
			mm_q  <= req.time_minutes;
			rs_q  <= req.relay_state;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.wr_en && (32'(idx_q) < TABLE_DEPTH)) begin
			mem[AW'(idx_q)] <= '{hour: hh_q, minute: mm_q, relay: rs_q};
		end
		rdata_q <= mem[rd_addr];
	end

	assign pend_none = 32'(pend_q) >= TABLE_DEPTH;
	assign pend_next = 32'(pend_q) + 32'd1;

	always_comb begin
		case (ctrl.rd_sel)
			des_pkg::RD_PEND:  rd_addr = AW'(pend_q);
			des_pkg::RD_PREV:  rd_addr = pend_none ? AW'(32'(count_q) - 32'd1)
			                                       : AW'(32'(pend_q) - 32'd1);
			des_pkg::RD_SCAN:  rd_addr = scan_q;
			default:           rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg.valid) begin
			if (32'(cfg.event_count) > TABLE_DEPTH) begin
				count_q <= des_pkg::COUNT_W'(TABLE_DEPTH);
			end else begin
				count_q <= cfg.event_count;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (ctrl.scan_clear) begin
			scan_q <= '0;
		end else if (ctrl.scan_inc) begin
			scan_q <= scan_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= PW'(TABLE_DEPTH);
		end else begin
			case (ctrl.pend_op)
				des_pkg::PEND_NONE:  pend_q <= PW'(TABLE_DEPTH);
				des_pkg::PEND_ZERO:  pend_q <= '0;
				des_pkg::PEND_SCAN:  pend_q <= PW'(scan_q);
				des_pkg::PEND_ADVANCE: begin
					if ((pend_next == 32'(count_q)) || (pend_next >= TABLE_DEPTH)) begin
						pend_q <= PW'(TABLE_DEPTH);
					end else begin
						pend_q <= PW'(pend_next);
					end
				end
				default: pend_q <= pend_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_q   <= 1'b0;
			applied_q <= 1'b0;
		end else if (ctrl.latch) begin
			applied_q <= 1'b0;
		end else if (ctrl.apply) begin
			relay_q   <= rdata_q.relay;
			applied_q <= 1'b1;
		end
	end

	// result register: load when empty or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctrl.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			rsp.relay_on        <= relay_q;
			rsp.event_applied   <= applied_q;
			rsp.pending_valid   <= !pend_none;
			rsp.pending_index   <= pend_q;
			rsp.pending_hours   <= pend_none ? '0 : rdata_q.hour;
			rsp.pending_minutes <= pend_none ? '0 : rdata_q.minute;
		end
	end

	assign rsp.valid = rsp_valid_q;

	always_comb begin
		stat.req_valid  = req.valid;
		stat.cmd        = cmd_q;
		stat.count_zero = (count_q == '0);
		stat.pend_none  = pend_none;
		stat.pend_zero  = (pend_q == '0);
		stat.mid_hit    = (hh_q == '0) && (mm_q == '0) &&
		                  (rdata_q.hour == '0) && (rdata_q.minute == '0);
		stat.later      = (rdata_q.hour > hh_q) ||
		                  ((rdata_q.hour == hh_q) && (rdata_q.minute > mm_q));
		stat.scan_last  = (32'(scan_q) + 32'd1) >= 32'(count_q);
		stat.out_busy   = rsp_valid_q && !rsp.ready;
	end

endmodule

FILE: dv/daily_event_scheduler_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// daily_event_scheduler_test
// Self-checking bench for the daily event scheduler. A queue of command items
// feeds a driver; a predictor tracks the event table, relay level and pending
// slot and expects one status item per command, which the monitor checks
// field by field. Directed items cover empty tables, midnight, wrap-around and
// out-of-range times; random phases then load ordered tables, look up the
// pending event and step through it, mixed with noise, under several event
// counts and random idling on both channels.
// ----------------------------------------------------------------------------
module daily_event_scheduler_test;

	localparam int DEPTH        = 16;
	localparam int RANDOM_ITEMS = 1850;
	localparam int QUIET_LIMIT  = 4000;
	localparam int DAY_MINUTES  = 1440;

	typedef struct packed {
		des_pkg::cmd_t              command;
		logic [des_pkg::SLOT_W-1:0] slot;
		logic [des_pkg::HOUR_W-1:0] hours;
		logic [des_pkg::MIN_W-1:0]  minutes;
		logic                       relay;
	} sched_item_t;

	typedef struct packed {
		logic                        relay_on;
		logic                        applied;
		logic                        pend_valid;
		logic [des_pkg::COUNT_W-1:0] pend_index;
		logic [des_pkg::HOUR_W-1:0]  pend_hours;
		logic [des_pkg::MIN_W-1:0]   pend_minutes;
	} sched_status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	des_req_if req_if();
	des_rsp_if #(.PEND_W(des_pkg::COUNT_W)) rsp_if();
	des_cfg_if cfg_if();

	daily_event_scheduler #(.TABLE_DEPTH(DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.cfg(cfg_if)
	);

	sched_item_t   command_queue[$];
	sched_status_t expected_status[$];
	sched_item_t   cur_item;
	sched_status_t want;

	logic [des_pkg::HOUR_W-1:0] hour_tab[DEPTH];
	logic [des_pkg::MIN_W-1:0]  min_tab[DEPTH];
	logic                       relay_tab[DEPTH];
	logic                       relay_lvl;
	int                         pend_slot;
	int                         evt_count;

	int cmd_seen[4];
	int queued = 0;
	int results_checked = 0;
	int applied_seen = 0;
	int pending_seen = 0;
	int err_count = 0;
	int cfg_writes = 0;
	int gap_left = 0;
	int stall_left = 0;
	int quiet_cycles = 0;
	bit idle_on = 1'b1;

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] exp_val);
		err_count++;
		if (err_count <= 40)
			$display("ERROR result %0d: %s got %0d expected %0d", results_checked, what,
				got, exp_val);
	endtask

	task automatic run_schedule_command(input sched_item_t it);
		sched_status_t st;
		logic          applied;
		int            i;
		applied = 1'b0;
		cmd_seen[it.command]++;
		case (it.command)
			des_pkg::CMD_WRITE: begin
				hour_tab[it.slot]  = it.hours;
				min_tab[it.slot]   = it.minutes;
				relay_tab[it.slot] = it.relay;
			end
			des_pkg::CMD_FIND: begin
				pend_slot = DEPTH;
				if (evt_count != 0) begin
					if (it.hours == 0 && it.minutes == 0 && hour_tab[0] == 0 && min_tab[0] == 0)
						pend_slot = 0;
					for (i = 0; i < evt_count && pend_slot == DEPTH; i++)
						if (hour_tab[i] > it.hours ||
								(hour_tab[i] == it.hours && min_tab[i] > it.minutes))
							pend_slot = i;
				end
			end
			des_pkg::CMD_RESTORE: begin
				if (evt_count != 0) begin
					if (pend_slot != DEPTH && pend_slot != 0) begin
						relay_lvl = relay_tab[pend_slot - 1];
						applied = 1'b1;
					end else if (pend_slot == DEPTH) begin
						relay_lvl = relay_tab[evt_count - 1];
						applied = 1'b1;
					end
				end
			end
			default: begin
				if (pend_slot != DEPTH) begin
					relay_lvl = relay_tab[pend_slot];
					applied = 1'b1;
					pend_slot++;
					if (pend_slot == evt_count)
						pend_slot = DEPTH;
				end
			end
		endcase
		st.relay_on     = relay_lvl;
		st.applied      = applied;
		st.pend_valid   = (pend_slot != DEPTH);
		st.pend_index   = pend_slot[des_pkg::COUNT_W-1:0];
		st.pend_hours   = st.pend_valid ? hour_tab[pend_slot] : '0;
		st.pend_minutes = st.pend_valid ? min_tab[pend_slot] : '0;
		expected_status.push_back(st);
	endtask

	task automatic queue_item(input des_pkg::cmd_t c, input int slot, input int hh,
			input int mm, input int rs);
		sched_item_t it;
		it.command = c;
		it.slot    = slot[des_pkg::SLOT_W-1:0];
		it.hours   = hh[des_pkg::HOUR_W-1:0];
		it.minutes = mm[des_pkg::MIN_W-1:0];
		it.relay   = rs[0];
		command_queue.push_back(it);
		queued++;
	endtask

	task automatic queue_noise(input des_pkg::cmd_t c);
		queue_item(c, $urandom_range(0, DEPTH - 1), $urandom_range(0, 31),
			$urandom_range(0, 63), $urandom_range(0, 1));
	endtask

	task automatic queue_find();
		int t;
		t = $urandom_range(0, DAY_MINUTES - 1);
		case ($urandom_range(0, 7))
			0: queue_item(des_pkg::CMD_FIND, $urandom_range(0, 15), 0, 0, $urandom_range(0, 1));
			1: queue_noise(des_pkg::CMD_FIND);
			default: queue_item(des_pkg::CMD_FIND, $urandom_range(0, 15), t / 60, t % 60,
				$urandom_range(0, 1));
		endcase
	endtask

	// ascending times, one slot per hour and a half of the day
	task automatic load_table(input int n, input bit midnight);
		int t;
		for (int i = 0; i < n; i++) begin
			t = i * 90 + $urandom_range(0, 89);
			if (midnight && i == 0)
				t = 0;
			queue_item(des_pkg::CMD_WRITE, i, t / 60, t % 60, $urandom_range(0, 1));
		end
	endtask

	task automatic set_event_count(input int value);
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.event_count <= value[des_pkg::COUNT_W-1:0];
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		cfg_if.valid <= 1'b0;
		evt_count = (value > DEPTH) ? DEPTH : value;
		cfg_writes++;
	endtask

	task automatic wait_drained();
		while (command_queue.size() != 0 || req_if.valid || expected_status.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (req_if.valid && req_if.ready)
				run_schedule_command(cur_item);
			if (!req_if.valid || req_if.ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					req_if.valid <= 1'b0;
				end else if (command_queue.size() != 0) begin
					cur_item = command_queue.pop_front();
					req_if.valid <= 1'b1;
					req_if.command <= cur_item.command;
					req_if.entry_index <= cur_item.slot;
					req_if.time_hours <= cur_item.hours;
					req_if.time_minutes <= cur_item.minutes;
					req_if.relay_state <= cur_item.relay;
					if (idle_on && $urandom_range(0, 4) == 0)
						gap_left <= $urandom_range(1, 6);
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				results_checked++;
				if (expected_status.size() == 0) begin
					report_mismatch("unexpected result", 8'd1, 8'd0);
				end else begin
					want = expected_status.pop_front();
					if (rsp_if.relay_on !== want.relay_on)
						report_mismatch("relay_on", 8'(rsp_if.relay_on), 8'(want.relay_on));
					if (rsp_if.event_applied !== want.applied)
						report_mismatch("event_applied", 8'(rsp_if.event_applied),
							8'(want.applied));
					if (rsp_if.pending_valid !== want.pend_valid)
						report_mismatch("pending_valid", 8'(rsp_if.pending_valid),
							8'(want.pend_valid));
					if (rsp_if.pending_index !== want.pend_index)
						report_mismatch("pending_index", 8'(rsp_if.pending_index),
							8'(want.pend_index));
					if (rsp_if.pending_hours !== want.pend_hours)
						report_mismatch("pending_hours", 8'(rsp_if.pending_hours),
							8'(want.pend_hours));
					if (rsp_if.pending_minutes !== want.pend_minutes)
						report_mismatch("pending_minutes", 8'(rsp_if.pending_minutes),
							8'(want.pend_minutes));
					applied_seen += want.applied;
					pending_seen += want.pend_valid;
				end
			end
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				rsp_if.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(0, 5);
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
				(cfg_if.valid && cfg_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("daily_event_scheduler test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int cnt;
		int phase_end;
		int phases;
		int directed_n;
		int n;
		req_if.valid = 1'b0;
		req_if.command = des_pkg::CMD_WRITE;
		req_if.entry_index = '0;
		req_if.time_hours = '0;
		req_if.time_minutes = '0;
		req_if.relay_state = 1'b0;
		rsp_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.event_count = '0;
		evt_count = 0;
		pend_slot = DEPTH;
		relay_lvl = 1'b0;
		phases = 0;
		for (int i = 0; i < 4; i++)
			cmd_seen[i] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// empty schedule, then fill every slot in time order
		set_event_count(0);
		queue_item(des_pkg::CMD_FIND, 0, 0, 0, 0);
		queue_item(des_pkg::CMD_RESTORE, 15, 31, 63, 1);
		queue_item(des_pkg::CMD_EXECUTE, 0, 0, 0, 0);
		queue_item(des_pkg::CMD_WRITE, 0, 0, 0, 1);
		for (int i = 1; i < DEPTH - 1; i++)
			queue_item(des_pkg::CMD_WRITE, i, (i * 90 + 7) / 60, (i * 90 + 7) % 60, i % 2);
		queue_item(des_pkg::CMD_WRITE, DEPTH - 1, 31, 63, 1);
		wait_drained();

		set_event_count(DEPTH);
		queue_item(des_pkg::CMD_FIND, 0, 0, 0, 0);
		queue_item(des_pkg::CMD_RESTORE, 0, 0, 0, 0);
		queue_item(des_pkg::CMD_EXECUTE, 0, 0, 0, 0);
		queue_item(des_pkg::CMD_RESTORE, 0, 0, 0, 0);
		queue_item(des_pkg::CMD_FIND, 0, 31, 63, 0);
		queue_item(des_pkg::CMD_RESTORE, 0, 0, 0, 0);
		queue_item(des_pkg::CMD_EXECUTE, 0, 0, 0, 0);
		queue_item(des_pkg::CMD_FIND, 0, 23, 59, 0);
		queue_item(des_pkg::CMD_EXECUTE, 0, 0, 0, 0);
		directed_n = queued;

		while (queued - directed_n < RANDOM_ITEMS) begin
			wait_drained();
			idle_on = (queued - directed_n < RANDOM_ITEMS - 250) && ($urandom_range(0, 4) != 0);
			case (phases % 6)
				0: cnt = DEPTH;
				1: cnt = 0;
				2: cnt = 31;
				3: cnt = 1;
				4: cnt = $urandom_range(DEPTH + 1, 30);
				default: cnt = $urandom_range(2, DEPTH - 1);
			endcase
			set_event_count(cnt);
			phases++;
			phase_end = queued + $urandom_range(40, 100);
			while (queued < phase_end) begin
				if ($urandom_range(0, 4) == 0) begin
					queue_noise(des_pkg::cmd_t'($urandom_range(0, 3)));
				end else begin
					if ($urandom_range(0, 2) == 0)
						load_table($urandom_range(1, DEPTH), $urandom_range(0, 1));
					if ($urandom_range(0, 5) != 0)
						queue_find();
					n = $urandom_range(1, 18);
					repeat (n)
						queue_noise($urandom_range(0, 9) < 7 ? des_pkg::CMD_EXECUTE
							: des_pkg::CMD_RESTORE);
				end
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		$display("Ran %0d items: %0d writes, %0d finds, %0d restores, %0d executes, %0d counts",
			queued, cmd_seen[des_pkg::CMD_WRITE], cmd_seen[des_pkg::CMD_FIND],
			cmd_seen[des_pkg::CMD_RESTORE], cmd_seen[des_pkg::CMD_EXECUTE], cfg_writes);
		$display("Checked %0d results: %0d applied an event, %0d had a pending event",
			results_checked, applied_seen, pending_seen);
		if (err_count == 0) begin
			$display("daily_event_scheduler test passed");
		end else begin
			$display("daily_event_scheduler test failed");
		end
		$finish;
	end

endmodule
